>>> hdl/pls_pkg.sv
// package: sizes, codes and control types of the positional list store
`default_nettype none
package pls_pkg;

   localparam int CAPACITY = 16;

   // field widths fixed by the request and response formats
   localparam int POS_W   = 5;
   localparam int LEN_W   = 5;
   localparam int MODE_W  = 2;
   localparam int VALUE_W = 32;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   // compare width: wide enough for the count and for a request position
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_EMPTY  = 2'd1,
      STATUS_BEYOND = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic             shift_up;    // insert at pos, later entries move up
      logic             shift_down;  // remove at pos, later entries move down
      logic [IDX_W-1:0] pos;
   } cell_cmd_type;

   // result selection handed from the controller to the output stage
   typedef struct packed {
      status_type       status;
      logic             read_hit;    // read value comes from cell at pos
      logic             read_err;    // failed read, value is -1
      logic [LEN_W-1:0] length;
   } result_ctl_type;

endpackage
`default_nettype wire

>>> hdl/pls_if.sv
// request and response channel interfaces of the positional list store
`default_nettype none
interface pls_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [pls_pkg::MODE_W-1:0]      mode;
   logic                                   at_end;
   logic        [pls_pkg::POS_W-1:0]       position;
   logic signed [pls_pkg::VALUE_W-1:0]     value;

   modport source (output valid, mode, at_end, position, value, input ready);
   modport sink   (input valid, mode, at_end, position, value, output ready);
endinterface

interface pls_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [pls_pkg::VALUE_W-1:0]     read_value;
   logic        [1:0]                      status;
   logic        [pls_pkg::LEN_W-1:0]       length;

   modport source (output valid, read_value, status, length, input ready);
   modport sink   (input valid, read_value, status, length, output ready);
endinterface
`default_nettype wire

>>> hdl/pls_cell.sv
// one list cell: holds an entry and takes its neighbour's on a shift
`default_nettype none
module pls_cell (
   input  wire logic                                clock,
   input  wire logic                                accept,
   input  wire pls_pkg::cell_cmd_type               cmd,
   input  wire logic        [pls_pkg::IDX_W-1:0]    cell_index,
   input  wire logic signed [pls_pkg::VALUE_W-1:0]  insert_value,
   input  wire logic signed [pls_pkg::VALUE_W-1:0]  left_data,
   input  wire logic signed [pls_pkg::VALUE_W-1:0]  right_data,
   output logic signed      [pls_pkg::VALUE_W-1:0]  data
);

   logic signed [pls_pkg::VALUE_W-1:0] data_ff;
   logic signed [pls_pkg::VALUE_W-1:0] data_in;
   logic                               load;

   always_comb begin
      data_in = data_ff;
      load    = 1'b0;
      if (cmd.shift_up) begin
         if (cell_index == cmd.pos) begin
            data_in = insert_value;
            load    = 1'b1;
         end else if (cell_index > cmd.pos) begin
            data_in = left_data;
            load    = 1'b1;
         end
      end else if (cmd.shift_down) begin
         if (cell_index >= cmd.pos) begin
            data_in = right_data;
            load    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && load) begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule
`default_nettype wire

>>> hdl/pls_ctrl.sv
// list controller: entry count, range checks and cell command
`default_nettype none
module pls_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              accept,
   input  wire logic [pls_pkg::MODE_W-1:0]        mode,
   input  wire logic                              at_end,
   input  wire logic [pls_pkg::POS_W-1:0]         position,
   output pls_pkg::cell_cmd_type                  cmd,
   output pls_pkg::result_ctl_type                result
);

   logic [pls_pkg::CNT_W-1:0] count_ff;
   logic [pls_pkg::CNT_W-1:0] count_in;
   logic [pls_pkg::CMP_W-1:0] count_ext;
   logic [pls_pkg::CMP_W-1:0] pos_ext;
   logic [pls_pkg::CMP_W-1:0] pos_ins;
   logic [pls_pkg::CMP_W-1:0] pos_acc;

   assign count_ext = pls_pkg::CMP_W'(count_ff);
   assign pos_ext   = pls_pkg::CMP_W'(position);
   assign pos_ins   = at_end ? count_ext : pos_ext;
   assign pos_acc   = at_end ? (count_ext - pls_pkg::CMP_W'(1)) : pos_ext;

   always_comb begin
      cmd             = '0;
      result.status   = pls_pkg::STATUS_OK;
      result.read_hit = 1'b0;
      result.read_err = 1'b0;
      count_in        = count_ff;
      case (mode)
         pls_pkg::MODE_INSERT: begin
            cmd.pos = pos_ins[pls_pkg::IDX_W-1:0];
            if (count_ff == '0 && pos_ins != '0) begin
               result.status = pls_pkg::STATUS_EMPTY;
            end else if (pos_ins > count_ext) begin
               result.status = pls_pkg::STATUS_BEYOND;
            end else if (count_ext >= pls_pkg::CMP_W'(pls_pkg::CAPACITY)) begin
               result.status = pls_pkg::STATUS_FULL;
            end else begin
               cmd.shift_up = 1'b1;
               count_in     = count_ff + pls_pkg::CNT_W'(1);
            end
         end
         pls_pkg::MODE_REMOVE, pls_pkg::MODE_READ: begin
            cmd.pos = pos_acc[pls_pkg::IDX_W-1:0];
            if (count_ff == '0) begin
               result.status   = pls_pkg::STATUS_EMPTY;
               result.read_err = (mode == pls_pkg::MODE_READ);
            end else if (pos_acc >= count_ext) begin
               result.status   = pls_pkg::STATUS_BEYOND;
               result.read_err = (mode == pls_pkg::MODE_READ);
            end else if (mode == pls_pkg::MODE_READ) begin
               result.read_hit = 1'b1;
            end else begin
               cmd.shift_down = 1'b1;
               count_in       = count_ff - pls_pkg::CNT_W'(1);
            end
         end
         default: begin
            // unused mode: no change, ok
         end
      endcase
      result.length = pls_pkg::LEN_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/positional_list_store.sv
// top level of the positional list store: cell row, controller, response register
//
//  channel   dir  handshake        payload
//  req_ch    in   valid / ready    mode, at_end, position, value
//  rsp_ch    out  valid / ready    read_value, status, length
//
// one request is taken per cycle while no held response blocks it; its response is
// registered and shows the cycle after acceptance, set by the single compare and
// shift of the cell row; reset clears the entry count and the response valid; cell
// contents stay undefined; a held response blocks the request side until it is
// taken; a new request can be taken in the same cycle as the held response
`default_nettype none
module positional_list_store (
   input  wire logic     clock,
   input  wire logic     reset,
   pls_req_if.sink       req_ch,
   pls_rsp_if.source     rsp_ch
);

   logic                            accept;
   pls_pkg::cell_cmd_type           cmd;
   pls_pkg::result_ctl_type         result;

   // entry of each cell, indexed by list position
   logic signed [pls_pkg::VALUE_W-1:0] cell_data [pls_pkg::CAPACITY];

   // response register
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic signed [pls_pkg::VALUE_W-1:0] rsp_value_ff;
   logic signed [pls_pkg::VALUE_W-1:0] rsp_value_in;
   logic [1:0]                         rsp_status_ff;
   logic [pls_pkg::LEN_W-1:0]          rsp_length_ff;

   // take a request whenever the response slot is free or being emptied
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   pls_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .mode     (req_ch.mode),
      .at_end   (req_ch.at_end),
      .position (req_ch.position),
      .cmd      (cmd),
      .result   (result)
   );

   // row of cells; ends tied off, their outer inputs never carry live data
   for (genvar g = 0; g < pls_pkg::CAPACITY; g++) begin : g_cell
      logic signed [pls_pkg::VALUE_W-1:0] left_data;
      logic signed [pls_pkg::VALUE_W-1:0] right_data;

      if (g == 0) begin : g_first
         assign left_data = req_ch.value;
      end else begin : g_mid_left
         assign left_data = cell_data[g-1];
      end

      if (g == pls_pkg::CAPACITY - 1) begin : g_last
         assign right_data = cell_data[g];
      end else begin : g_mid_right
         assign right_data = cell_data[g+1];
      end

      pls_cell u_cell (
         .clock        (clock),
         .accept       (accept),
         .cmd          (cmd),
         .cell_index   (pls_pkg::IDX_W'(g)),
         .insert_value (req_ch.value),
         .left_data    (left_data),
         .right_data   (right_data),
         .data         (cell_data[g])
      );
   end

   // read value: selected entry on a good read, all ones on a failed one, else 0
   always_comb begin
      if (result.read_hit) begin
         rsp_value_in = cell_data[cmd.pos];
      end else if (result.read_err) begin
         rsp_value_in = '1;
      end else begin
         rsp_value_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload loads only with a new request, so a stalled response holds
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= result.status;
         rsp_length_ff <= result.length;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = rsp_value_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.length     = rsp_length_ff;

endmodule
`default_nettype wire

>>> sim/positional_list_store_tb.sv
// testbench of the positional list store: directed table, then random requests against a predictor
`timescale 1ns / 1ps
module positional_list_store_tb;

   // mode code that the block ignores
   localparam logic [pls_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

   localparam int RANDOM_OPS  = 1020;  // random requests after the directed table
   localparam int TAIL_OPS    = 150;   // closing stretch with no idling on either side
   localparam int STALL_LIMIT = 2000;  // cycles with no handshake before giving up
   localparam int DRAIN_WAIT  = 8;     // response is registered; extra wait for anything stray

   // one request as it goes into the block
   typedef struct {
      logic [pls_pkg::MODE_W-1:0]         mode;
      logic                               at_end;
      logic [pls_pkg::POS_W-1:0]          position;
      logic signed [pls_pkg::VALUE_W-1:0] value;
   } list_op_type;

   // one response as it comes out
   typedef struct {
      logic signed [pls_pkg::VALUE_W-1:0] read_value;
      pls_pkg::status_type                status;
      logic [pls_pkg::LEN_W-1:0]          length;
   } list_rsp_type;

   // directed row: a request, repeated with the value counting up, and an
   // optional hand-written response
   typedef struct {
      list_op_type  op;
      int           reps;
      bit           typed;
      list_rsp_type want;
   } script_row_type;

   logic clock;
   logic reset;

   pls_req_if req_ch ();
   pls_rsp_if rsp_ch ();

   positional_list_store dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow copy of the list, updated as each request is taken
   logic signed [pls_pkg::VALUE_W-1:0] shadow [pls_pkg::CAPACITY];
   int                                 shadow_count = 0;

   list_rsp_type   pending_rsps [$];  // responses still owed by the block, oldest first
   script_row_type script [$];
   int             errors = 0;
   int             quiet_cycles = 0;
   bit             calm = 1'b0;       // sender is in a stretch with no gaps
   bit             tail = 1'b0;       // closing stretch, nobody idles

   // apply one request to the shadow list and give the response it should produce
   function automatic list_rsp_type list_apply(list_op_type op);
      list_rsp_type r;
      int           slot;
      r.read_value = '0;
      r.status     = pls_pkg::STATUS_OK;
      case (op.mode)
         pls_pkg::MODE_INSERT: begin
            slot = op.at_end ? shadow_count : int'(op.position);
            // empty check wins over beyond, and beyond wins over full
            if (shadow_count == 0 && slot != 0) r.status = pls_pkg::STATUS_EMPTY;
            else if (slot > shadow_count) r.status = pls_pkg::STATUS_BEYOND;
            else if (shadow_count >= pls_pkg::CAPACITY) r.status = pls_pkg::STATUS_FULL;
            else begin
               for (int i = shadow_count; i > slot; i--) shadow[i] = shadow[i-1];
               shadow[slot] = op.value;
               shadow_count++;
            end
         end
         pls_pkg::MODE_REMOVE, pls_pkg::MODE_READ: begin
            slot = op.at_end ? shadow_count - 1 : int'(op.position);
            if (shadow_count == 0) r.status = pls_pkg::STATUS_EMPTY;
            else if (slot >= shadow_count) r.status = pls_pkg::STATUS_BEYOND;
            else if (op.mode == pls_pkg::MODE_READ) r.read_value = shadow[slot];
            else begin
               for (int i = slot; i + 1 < shadow_count; i++) shadow[i] = shadow[i+1];
               shadow_count--;
            end
            // a failed read hands back all ones
            if (r.status != pls_pkg::STATUS_OK && op.mode == pls_pkg::MODE_READ)
               r.read_value = -1;
         end
         default: ;
      endcase
      r.length = shadow_count[pls_pkg::LEN_W-1:0];
      return r;
   endfunction

   // random request, mostly well formed so that the list fills and drains
   function automatic list_op_type draw_op(bit growing);
      list_op_type op;
      int          pick;
      int          ins_pct;
      int          rem_pct;
      ins_pct = growing ? 60 : 20;
      rem_pct = growing ? 15 : 55;
      pick    = $urandom_range(0, 99);
      if (pick < ins_pct) op.mode = pls_pkg::MODE_INSERT;
      else if (pick < ins_pct + rem_pct) op.mode = pls_pkg::MODE_REMOVE;
      else if (pick < 95) op.mode = pls_pkg::MODE_READ;
      else op.mode = MODE_SPARE;
      op.at_end = ($urandom_range(0, 4) == 0);
      // one in five positions anywhere in the field, the rest inside the list
      if ($urandom_range(0, 4) == 0)
         op.position = pls_pkg::POS_W'($urandom_range(0, 31));
      else if (op.mode == pls_pkg::MODE_INSERT)
         op.position = pls_pkg::POS_W'($urandom_range(0, shadow_count));
      else if (shadow_count == 0)
         op.position = '0;
      else
         op.position = pls_pkg::POS_W'($urandom_range(0, shadow_count - 1));
      case ($urandom_range(0, 9))
         0:       op.value = 32'h7fff_ffff;
         1:       op.value = 32'h8000_0000;
         2:       op.value = -1;
         3:       op.value = '0;
         default: op.value = $urandom;
      endcase
      return op;
   endfunction

   task automatic add_row(input logic [pls_pkg::MODE_W-1:0] mode, input logic at_end,
                          input logic [pls_pkg::POS_W-1:0] position,
                          input logic signed [pls_pkg::VALUE_W-1:0] value, input int reps,
                          input bit typed, input logic signed [pls_pkg::VALUE_W-1:0] rv,
                          input pls_pkg::status_type st,
                          input logic [pls_pkg::LEN_W-1:0] len);
      script_row_type row;
      row.op.mode         = mode;
      row.op.at_end       = at_end;
      row.op.position     = position;
      row.op.value        = value;
      row.reps            = reps;
      row.typed           = typed;
      row.want.read_value = rv;
      row.want.status     = st;
      row.want.length     = len;
      script.push_back(row);
   endtask

   // present one request and hold it until taken; the predictor runs at the
   // accepting edge, a hand-written response replaces its answer when given
   task automatic send_op(input list_op_type op, input bit typed, input list_rsp_type want);
      list_rsp_type predicted;
      req_ch.valid    <= 1'b1;
      req_ch.mode     <= op.mode;
      req_ch.at_end   <= op.at_end;
      req_ch.position <= op.position;
      req_ch.value    <= op.value;
      do @(posedge clock); while (!req_ch.ready);
      predicted = list_apply(op);
      pending_rsps.push_back(typed ? want : predicted);
   endtask

   // sender gap, now and then, outside the calm stretches
   task automatic maybe_gap();
      if (!calm && !tail && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: stall bursts between open stretches
   initial begin
      forever begin
         if (!calm && !tail && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   // response check against the oldest owed response
   always @(posedge clock) begin : rsp_check
      list_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsps.size() == 0) begin
            $error("response with none owed: read_value %0d status %0d length %0d",
                   rsp_ch.read_value, rsp_ch.status, rsp_ch.length);
            errors++;
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_ch.read_value !== want.read_value) begin
               $error("read_value: expected %0d, got %0d", want.read_value, rsp_ch.read_value);
               errors++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               errors++;
            end
            if (rsp_ch.length !== want.length) begin
               $error("length: expected %0d, got %0d", want.length, rsp_ch.length);
               errors++;
            end
         end
      end
   end

   // watchdog: too long without a handshake on either channel ends the run
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      list_op_type  op;
      list_rsp_type none;
      bit           growing;
      none         = '{read_value: '0, status: pls_pkg::STATUS_OK, length: '0};
      growing      = 1'b1;
      reset        <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.mode     <= pls_pkg::MODE_INSERT;
      req_ch.at_end   <= 1'b0;
      req_ch.position <= '0;
      req_ch.value    <= '0;

      // directed table: empty list, extremes, each status, fill to full
      // columns: mode, end, pos, value, reps, typed, rv, status, len
      add_row(pls_pkg::MODE_READ, 0, 0, 0, 1, 1, -1, pls_pkg::STATUS_EMPTY, 0);
      add_row(pls_pkg::MODE_REMOVE, 1, 0, 0, 1, 1, 0, pls_pkg::STATUS_EMPTY, 0);
      // insert at a nonzero position into an empty list
      add_row(pls_pkg::MODE_INSERT, 0, 5, 123, 1, 1, 0, pls_pkg::STATUS_EMPTY, 0);
      add_row(MODE_SPARE, 1, 31, -1, 1, 1, 0, pls_pkg::STATUS_OK, 0);
      add_row(pls_pkg::MODE_INSERT, 0, 0, 32'h7fff_ffff, 1, 1, 0, pls_pkg::STATUS_OK, 1);
      add_row(pls_pkg::MODE_INSERT, 1, 31, 32'h8000_0000, 1, 1, 0, pls_pkg::STATUS_OK, 2);
      add_row(pls_pkg::MODE_INSERT, 0, 1, -1, 1, 1, 0, pls_pkg::STATUS_OK, 3);
      // a good read of all ones, then the list end
      add_row(pls_pkg::MODE_READ, 0, 1, 0, 1, 1, -1, pls_pkg::STATUS_OK, 3);
      add_row(pls_pkg::MODE_READ, 1, 0, 0, 1, 1, 32'h8000_0000, pls_pkg::STATUS_OK, 3);
      add_row(pls_pkg::MODE_REMOVE, 0, 31, 0, 1, 1, 0, pls_pkg::STATUS_BEYOND, 3);
      add_row(pls_pkg::MODE_INSERT, 0, 4, 7, 1, 1, 0, pls_pkg::STATUS_BEYOND, 3);
      add_row(pls_pkg::MODE_REMOVE, 0, 0, 0, 1, 1, 0, pls_pkg::STATUS_OK, 2);
      // fill up with appends
      add_row(pls_pkg::MODE_INSERT, 1, 0, 32'h5a5a_0000, 14, 0, 0, pls_pkg::STATUS_OK, 0);
      add_row(pls_pkg::MODE_INSERT, 0, 0, 1, 1, 1, 0, pls_pkg::STATUS_FULL, 16);
      // beyond is checked before full
      add_row(pls_pkg::MODE_INSERT, 0, 17, 1, 1, 1, 0, pls_pkg::STATUS_BEYOND, 16);
      add_row(pls_pkg::MODE_READ, 0, 15, 0, 1, 0, 0, pls_pkg::STATUS_OK, 0);
      add_row(pls_pkg::MODE_READ, 0, 16, 0, 1, 1, -1, pls_pkg::STATUS_BEYOND, 16);
      add_row(pls_pkg::MODE_REMOVE, 1, 0, 0, 1, 1, 0, pls_pkg::STATUS_OK, 15);
      add_row(pls_pkg::MODE_READ, 0, 0, 0, 1, 1, -1, pls_pkg::STATUS_OK, 15);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         for (int k = 0; k < script[i].reps; k++) begin
            op       = script[i].op;
            op.value = op.value + k;
            maybe_gap();
            send_op(op, script[i].typed, script[i].want);
         end
      end

      // random part: fill and drain phases, gaps switched off in some stretches
      for (int n = 0; n < RANDOM_OPS; n++) begin
         calm = ((n / 80) % 3 == 0);
         tail = (n >= RANDOM_OPS - TAIL_OPS);
         // halfway, hold off until the block owes nothing
         if (n == RANDOM_OPS / 2) begin
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (pending_rsps.size() != 0);
         end
         if (shadow_count >= pls_pkg::CAPACITY) growing = 1'b0;
         else if (shadow_count == 0) growing = 1'b1;
         else if ($urandom_range(0, 49) == 0) growing = ~growing;
         maybe_gap();
         send_op(draw_op(growing), 1'b0, none);
      end
      req_ch.valid <= 1'b0;

      // drain the owed responses, then wait DRAIN_WAIT for anything stray
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
